// File: sv/mtcd_pkg.sv
// ----------------------------------------------------------------------------
// mtcd_pkg: shared constants for the minutes to calendar date block
// Calendar constants in minutes and the month length table.
// ----------------------------------------------------------------------------
package mtcd_pkg;

  localparam int unsigned BASE_YEAR_W   = 14;
  localparam int unsigned YEAR_W        = 15;
  localparam int unsigned DAY_W         = 5;
  localparam int unsigned MONTH_W       = 4;
  localparam int unsigned HOUR_W        = 5;
  localparam int unsigned MINUTE_W      = 6;
  localparam int unsigned IN_W          = 32;

  localparam logic [BASE_YEAR_W-1:0] BASE_YEAR_RESET = 14'd2022;

  // One Gregorian 400-year cycle is exactly 146097 days.
  localparam logic [27:0] CYCLE_MINUTES = 28'd210379680;
  localparam logic [19:0] YEAR365_MIN   = 20'd525600;
  localparam logic [19:0] YEAR366_MIN   = 20'd527040;
  localparam logic [10:0] DAY_MIN       = 11'd1440;
  localparam logic [5:0]  HOUR_MIN      = 6'd60;

  localparam logic [8:0]  CYCLE_YEARS   = 9'd400;
  localparam logic [8:0]  LAST_IN_CYCLE = 9'd399;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;

  // Length of a month in minutes; February grows by a day in a leap year.
  function automatic logic [15:0] month_minutes(input logic [MONTH_W-1:0] month,
                                                input logic leap);
    logic [15:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 16'd44640;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 16'd43200;
      FEBRUARY:                                   len = leap ? 16'd41760 : 16'd40320;
      default:                                    len = 16'd44640;
    endcase
    return len;
  endfunction

endpackage

// File: sv/minutes_to_calendar_date.sv
// ----------------------------------------------------------------------------
// minutes_to_calendar_date: epoch minutes to Gregorian date and time
// The block turns a count of minutes since 00:00 on 1 January of the base
// year into day, month, year, hour and minute under the full Gregorian leap
// rule. One item is worked on at a time by a single compare and subtract unit
// stepped by a small sequencer. For each item it first reduces the base year
// modulo 400, then removes whole 400-year cycles, then single years, then
// months, then days and then hours, and in a last step it hands the result
// to the output register. Of these steps, the year loop through one 400-year
// cycle can run longest; the block takes no new item until it is done. A
// finished result waits in its output register while
// the next item is taken; the last step waits for as long as that register is
// full and not being drained. The base year is written through the cfg_ port,
// which is only ready while the block is idle; a write offered in the same
// cycle as an input item goes first, so the item sees the new base year. The
// base year resets to 2022.
// ----------------------------------------------------------------------------
module minutes_to_calendar_date
  import mtcd_pkg::*;
#(
  parameter int unsigned MINUTE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [BASE_YEAR_W-1:0] cfg_base_year,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [IN_W-1:0]        in_elapsed_minutes,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DAY_W-1:0]       out_day_of_month,
  output logic [MONTH_W-1:0]     out_month_number,
  output logic [YEAR_W-1:0]      out_year_number,
  output logic [HOUR_W-1:0]      out_hour_of_day,
  output logic [MINUTE_W-1:0]    out_minute_of_hour
);

  // Only the low MINUTE_BITS of the 32-bit input count, and never more than 32.
  localparam int unsigned EFF_W = (MINUTE_BITS < IN_W) ? MINUTE_BITS : IN_W;
  // The shared unit must also hold the 400-year cycle length.
  localparam int unsigned AW    = (EFF_W > 29) ? EFF_W : 29;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CYCLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_HOUR,
    ST_FIN
  } state_t;

  state_t                 state_r;
  logic [BASE_YEAR_W-1:0] base_year_r;
  logic [AW-1:0]          rem_r;
  logic [BASE_YEAR_W-1:0] mod_r;
  logic [YEAR_W-1:0]      year_r;
  logic [MONTH_W-1:0]     month_r;
  logic [DAY_W-1:0]       day_r;
  logic [HOUR_W-1:0]      hour_r;

  logic                   out_valid_r;
  logic [DAY_W-1:0]       out_day_r;
  logic [MONTH_W-1:0]     out_month_r;
  logic [YEAR_W-1:0]      out_year_r;
  logic [HOUR_W-1:0]      out_hour_r;
  logic [MINUTE_W-1:0]    out_minute_r;

  logic [AW-1:0]          op_a;
  logic [AW-1:0]          op_b;
  logic [AW-1:0]          diff;
  logic                   ge;
  logic                   leap;
  logic [EFF_W-1:0]       in_masked;

  assign in_masked = in_elapsed_minutes[EFF_W-1:0];

  // Once the base year has been reduced, mod_r holds the working year modulo
  // 400, which is all the leap rule needs: a multiple of 400 is leap, and so is
  // any other multiple of four that is not a whole century.
  assign leap = (mod_r == '0) ||
                ((mod_r[1:0] == 2'b00) && (mod_r != 14'd100) &&
                 (mod_r != 14'd200) && (mod_r != 14'd300));

  // Operand selection for the shared unit, one comparison per state.
  always_comb begin
    op_a = rem_r;
    op_b = '0;
    case (state_r)
      ST_MOD: begin
        op_a = AW'(mod_r);
        op_b = AW'(CYCLE_YEARS);
      end
      ST_CYCLE: op_b = AW'(CYCLE_MINUTES);
      ST_YEAR:  op_b = leap ? AW'(YEAR366_MIN) : AW'(YEAR365_MIN);
      ST_MONTH: op_b = AW'(month_minutes(month_r, leap));
      ST_DAY:   op_b = AW'(DAY_MIN);
      ST_HOUR:  op_b = AW'(HOUR_MIN);
      default:  op_b = '0;
    endcase
  end

  mtcd_sub #(
    .WIDTH (AW)
  ) u_sub (
    .op_a (op_a),
    .op_b (op_b),
    .diff (diff),
    .ge   (ge)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      base_year_r <= BASE_YEAR_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        base_year_r <= cfg_base_year;
      end
      // In the last step a drained register is refilled below instead.
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            rem_r   <= AW'(in_masked);
            mod_r   <= base_year_r;
            year_r  <= YEAR_W'(base_year_r);
            month_r <= 4'd1;
            day_r   <= 5'd1;
            hour_r  <= '0;
            state_r <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (ge) begin
            mod_r <= diff[BASE_YEAR_W-1:0];
          end else begin
            state_r <= ST_CYCLE;
          end
        end
        ST_CYCLE: begin
          // Whole 400-year cycles leave the year modulo 400 unchanged.
          if (ge) begin
            rem_r  <= diff;
            year_r <= year_r + YEAR_W'(CYCLE_YEARS);
          end else begin
            state_r <= ST_YEAR;
          end
        end
        ST_YEAR: begin
          if (ge) begin
            rem_r  <= diff;
            year_r <= year_r + YEAR_W'(1);
            mod_r  <= (mod_r == BASE_YEAR_W'(LAST_IN_CYCLE)) ? '0 :
                      mod_r + BASE_YEAR_W'(1);
          end else begin
            state_r <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (ge && (month_r != DECEMBER)) begin
            rem_r   <= diff;
            month_r <= month_r + MONTH_W'(1);
          end else begin
            state_r <= ST_DAY;
          end
        end
        ST_DAY: begin
          if (ge) begin
            rem_r <= diff;
            day_r <= day_r + DAY_W'(1);
          end else begin
            state_r <= ST_HOUR;
          end
        end
        ST_HOUR: begin
          if (ge) begin
            rem_r  <= diff;
            hour_r <= hour_r + HOUR_W'(1);
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          // The output register takes the result once it is empty or emptying.
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_day_r    <= day_r;
            out_month_r  <= month_r;
            out_year_r   <= year_r;
            out_hour_r   <= hour_r;
            out_minute_r <= rem_r[MINUTE_W-1:0];
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign cfg_ready          = (state_r == ST_IDLE);
  assign in_ready           = (state_r == ST_IDLE) && !cfg_valid;
  assign out_valid          = out_valid_r;
  assign out_day_of_month   = out_day_r;
  assign out_month_number   = out_month_r;
  assign out_year_number    = out_year_r;
  assign out_hour_of_day    = out_hour_r;
  assign out_minute_of_hour = out_minute_r;

  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again straight after an accepted item");

  // A result that is not taken is never dropped.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("pending result lost");

  // The year and month steps see the working year reduced modulo 400.
  a_mod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR || state_r == ST_MONTH) |-> (mod_r < BASE_YEAR_W'(CYCLE_YEARS)))
    else $error("year modulo 400 out of range");

  // Every delivered month is a real month.
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_number >= 4'd1 && out_month_number <= DECEMBER))
    else $error("month out of range");

endmodule

// File: sv/mtcd_sub.sv
// ----------------------------------------------------------------------------
// mtcd_sub: shared compare and subtract unit
// Gives a - b and whether a is at least b.
// ----------------------------------------------------------------------------
module mtcd_sub #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  output logic [WIDTH-1:0] diff,
  output logic             ge
);

  logic [WIDTH:0] full;

  // The borrow out of the extended subtraction, inverted, is the compare result.
  assign full = {1'b0, op_a} - {1'b0, op_b};
  assign diff = full[WIDTH-1:0];
  assign ge   = ~full[WIDTH];

endmodule
